FILE: rtl/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg: shared definitions of the cubic Bezier flattener
// Widths, register defaults, datapath operation codes and the command and
// status structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cbf_pkg;

    localparam int COORD_W               = 32;
    localparam int CNT_W                 = 11;
    localparam int LEN_W                 = 25;
    localparam int SQ_W                  = 66;
    localparam int ROOT_W                = 33;
    localparam int SREM_W                = 35;
    localparam int TOTAL_W               = 35;
    localparam int SQRT_STEPS            = 33;
    localparam int QDIV_STEPS            = 35;
    localparam int PDIV_STEPS            = 32;
    localparam int STEP_W                = 6;
    localparam int MIN_SEGMENT_STEPS     = 6;
    localparam int SEG_STEPS_CAP_DEFAULT = 64;
    localparam int IN_DATA_W             = 6 * COORD_W;
    localparam int OUT_DATA_W            = 2 * COORD_W;
    localparam int APB_ADDR_W            = 3;
    localparam int APB_DATA_W            = 32;

    localparam logic [CNT_W-1:0] POINT_LIMIT_RESET = CNT_W'(1024);
    localparam logic [LEN_W-1:0] STEP_LENGTH_RESET = LEN_W'(196608);

    localparam logic REG_POINT_LIMIT = 1'b0;
    localparam logic REG_STEP_LENGTH = 1'b1;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_SEGMENT = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SQRT_STEP,
        OP_EDGE_ADD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_N_SET,
        OP_N_SQ,
        OP_N_CUBE,
        OP_W_SQ,
        OP_W_MUL,
        OP_TERM,
        OP_ACC,
        OP_PDIV_INIT,
        OP_PDIV_STEP,
        OP_EMIT_PT,
        OP_EMIT_START,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] edge_sel;
        logic [1:0] term;
    } cmd_t;

    typedef struct packed {
        logic j_eq_n;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/cbf_dp.sv
// ----------------------------------------------------------------------------
// cbf_dp: datapath of the cubic Bezier flattener
// Edge lengths by digit-serial square root, step count by restoring division,
// Bernstein blend by one multiplier per axis and a bit-serial rounding divide.
// ----------------------------------------------------------------------------
`default_nettype none

module cbf_dp
    import cbf_pkg::*;
#(
    parameter int SEG_STEPS_CAP = SEG_STEPS_CAP_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output      sts_t                  sts,
    input  wire logic [IN_DATA_W-1:0]  in_data,
    input  wire logic [LEN_W-1:0]      step_length,
    output      logic [OUT_DATA_W-1:0] point
);

    localparam int NW = $clog2(SEG_STEPS_CAP + 1);
    localparam int CW = 3 * NW;
    localparam int AW = CW + 33;
    localparam int MW = CW + 32;

    logic signed [COORD_W-1:0] cur_reg [2];
    logic signed [COORD_W-1:0] c1_reg  [2];
    logic signed [COORD_W-1:0] c2_reg  [2];
    logic signed [COORD_W-1:0] end_reg [2];
    logic signed [COORD_W-1:0] out_reg [2];

    logic signed [COORD_W-1:0] ax, ay, bx, by;
    logic signed [COORD_W:0]   dx, dy;
    logic [COORD_W:0]          dxm, dym, sq_in;
    logic [SQ_W-1:0]           sq_prod, sq_reg, sq_sum, sh_reg;
    logic [SREM_W-1:0]         srem_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [SREM_W+1:0]         srem_try, strial;
    logic [TOTAL_W-1:0]        total_reg, dq_reg;
    logic [LEN_W-1:0]          len, drem_reg;
    logic [LEN_W:0]            dtry;
    logic                      dge;
    logic [NW-1:0]             n_reg, j_reg, k, n_next, q1;
    logic [2*NW-1:0]           n2_reg, k2_reg, j2_reg;
    logic [CW-1:0]             d_reg, half;
    logic [CW-1:0]             w_reg [4];
    logic [CW+1:0]             w1_full, w2_full;
    logic [CW-1:0]             w_sel;
    logic signed [AW-1:0]      prod_reg [2];
    logic signed [AW-1:0]      acc_reg  [2];
    logic signed [COORD_W-1:0] p_sel [2];
    logic [AW-1:0]             abs_acc [2];
    logic [MW-1:0]             mag [2];
    logic                      neg_reg [2];
    logic [CW-1:0]             prem_reg [2];
    logic [31:0]               plo_reg [2];
    logic [CW:0]               ptry [2];
    logic                      pge [2];

    // edge end points: current to ctrl1, ctrl1 to ctrl2, ctrl2 to end
    always_comb
    begin
        case (cmd.edge_sel)
            2'd0:
            begin
                ax = cur_reg[0]; ay = cur_reg[1]; bx = c1_reg[0]; by = c1_reg[1];
            end
            2'd1:
            begin
                ax = c1_reg[0]; ay = c1_reg[1]; bx = c2_reg[0]; by = c2_reg[1];
            end
            default:
            begin
                ax = c2_reg[0]; ay = c2_reg[1]; bx = end_reg[0]; by = end_reg[1];
            end
        endcase
    end

    assign dx      = {bx[COORD_W-1], bx} - {ax[COORD_W-1], ax};
    assign dy      = {by[COORD_W-1], by} - {ay[COORD_W-1], ay};
    assign dxm     = dx[COORD_W] ? (~dx + 1'b1) : dx;
    assign dym     = dy[COORD_W] ? (~dy + 1'b1) : dy;
    assign sq_in   = (cmd.op == OP_SQ_X) ? dxm : dym;
    assign sq_prod = SQ_W'(sq_in) * SQ_W'(sq_in);
    assign sq_sum  = sq_reg + sq_prod;

    assign srem_try = {srem_reg, sh_reg[SQ_W-1:SQ_W-2]};
    assign strial   = {2'b00, root_reg, 2'b01};

    assign len  = (step_length == '0) ? LEN_W'(1) : step_length;
    assign dtry = {drem_reg, dq_reg[TOTAL_W-1]};
    assign dge  = dtry >= {1'b0, len};

    always_comb
    begin
        q1     = NW'(dq_reg) + 1'b1;
        n_next = q1;
        if (dq_reg >= TOTAL_W'(SEG_STEPS_CAP))
        begin
            n_next = NW'(SEG_STEPS_CAP);
        end
        else if (q1 < NW'(MIN_SEGMENT_STEPS))
        begin
            n_next = NW'(MIN_SEGMENT_STEPS);
        end
        if (n_next > NW'(SEG_STEPS_CAP))
        begin
            n_next = NW'(SEG_STEPS_CAP);
        end
    end

    assign k       = n_reg - j_reg;
    assign half    = d_reg >> 1;
    assign w1_full = (CW+2)'(k2_reg) * (CW+2)'(j_reg) * (CW+2)'(3);
    assign w2_full = (CW+2)'(j2_reg) * (CW+2)'(k) * (CW+2)'(3);
    assign w_sel   = w_reg[cmd.term];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            case (cmd.term)
                2'd0:    p_sel[l] = cur_reg[l];
                2'd1:    p_sel[l] = c1_reg[l];
                2'd2:    p_sel[l] = c2_reg[l];
                default: p_sel[l] = end_reg[l];
            endcase
            abs_acc[l] = acc_reg[l][AW-1] ? AW'(-acc_reg[l]) : AW'(acc_reg[l]);
            mag[l]     = MW'(abs_acc[l]) + MW'(half);
            ptry[l]    = {prem_reg[l], plo_reg[l][31]};
            pge[l]     = ptry[l] >= {1'b0, d_reg};
        end
    end

    // current point is architectural state and resets to the origin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg[0] <= '0;
            cur_reg[1] <= '0;
        end
        else if (cmd.op == OP_EMIT_START || cmd.op == OP_FINISH)
        begin
            cur_reg[0] <= end_reg[0];
            cur_reg[1] <= end_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                c1_reg[0]  <= in_data[31:0];
                c1_reg[1]  <= in_data[63:32];
                c2_reg[0]  <= in_data[95:64];
                c2_reg[1]  <= in_data[127:96];
                end_reg[0] <= in_data[159:128];
                end_reg[1] <= in_data[191:160];
                total_reg  <= '0;
            end
            OP_SQ_X:
            begin
                sq_reg <= sq_prod;
            end
            OP_SQ_Y:
            begin
                sh_reg   <= sq_sum;
                srem_reg <= '0;
                root_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                sh_reg <= {sh_reg[SQ_W-3:0], 2'b00};
                if (srem_try >= strial)
                begin
                    srem_reg <= SREM_W'(srem_try - strial);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= srem_try[SREM_W-1:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            OP_EDGE_ADD:
            begin
                total_reg <= total_reg + TOTAL_W'(root_reg);
            end
            OP_DIV_INIT:
            begin
                dq_reg   <= total_reg;
                drem_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                drem_reg <= dge ? LEN_W'(dtry - {1'b0, len}) : dtry[LEN_W-1:0];
                dq_reg   <= {dq_reg[TOTAL_W-2:0], dge};
            end
            OP_N_SET:
            begin
                n_reg <= n_next;
                j_reg <= NW'(1);
            end
            OP_N_SQ:
            begin
                n2_reg <= (2*NW)'(n_reg) * (2*NW)'(n_reg);
            end
            OP_N_CUBE:
            begin
                d_reg <= CW'(n2_reg) * CW'(n_reg);
            end
            OP_W_SQ:
            begin
                k2_reg <= (2*NW)'(k) * (2*NW)'(k);
                j2_reg <= (2*NW)'(j_reg) * (2*NW)'(j_reg);
            end
            OP_W_MUL:
            begin
                w_reg[0] <= CW'(k2_reg) * CW'(k);
                w_reg[1] <= w1_full[CW-1:0];
                w_reg[2] <= w2_full[CW-1:0];
                w_reg[3] <= CW'(j2_reg) * CW'(j_reg);
            end
            OP_TERM:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    prod_reg[l] <= AW'(signed'({1'b0, w_sel})) * AW'(p_sel[l]);
                    acc_reg[l]  <= (cmd.term == 2'd0) ? '0 : acc_reg[l] + prod_reg[l];
                end
            end
            OP_ACC:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    acc_reg[l] <= acc_reg[l] + prod_reg[l];
                end
            end
            OP_PDIV_INIT:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    neg_reg[l]  <= acc_reg[l][AW-1];
                    prem_reg[l] <= mag[l][MW-1:32];
                    plo_reg[l]  <= mag[l][31:0];
                end
            end
            OP_PDIV_STEP:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    prem_reg[l] <= pge[l] ? CW'(ptry[l] - {1'b0, d_reg}) : ptry[l][CW-1:0];
                    plo_reg[l]  <= {plo_reg[l][30:0], pge[l]};
                end
            end
            OP_EMIT_PT:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    out_reg[l] <= neg_reg[l] ? -plo_reg[l] : plo_reg[l];
                end
                j_reg <= j_reg + 1'b1;
            end
            OP_EMIT_START:
            begin
                out_reg[0] <= end_reg[0];
                out_reg[1] <= end_reg[1];
            end
            default:
            begin
            end
        endcase
    end

    assign sts.j_eq_n = (j_reg == n_reg);
    assign point      = {out_reg[1], out_reg[0]};

endmodule

`default_nettype wire

FILE: rtl/cbf_ctrl.sv
// ----------------------------------------------------------------------------
// cbf_ctrl: sequencer of the cubic Bezier flattener
// Steps the datapath through edge lengths, step count and one blend per
// point; owns the point count and the output valid and last flags.
// ----------------------------------------------------------------------------
`default_nettype none

module cbf_ctrl
    import cbf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_cmd,
    output      logic             in_ready,
    input  wire logic             out_ready,
    output      logic             out_valid,
    output      logic             out_last,
    input  wire logic [CNT_W-1:0] point_limit,
    input  wire sts_t             sts,
    output      cmd_t             cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_SQX, S_SQY, S_SQRT, S_EADD, S_DIVI, S_DIV,
        S_NSET, S_NSQ, S_NCUBE, S_PCHK, S_WSQ, S_WMUL, S_TERM, S_ACC,
        S_PDI, S_PDIV, S_EMIT, S_FIN
    } state_t;

    state_t           state_reg;
    logic [STEP_W-1:0] step_reg;
    logic [1:0]       edge_reg, term_reg;
    logic [CNT_W-1:0] count_reg;
    logic             out_valid_reg, out_last_reg;
    logic             accept, out_free, last_pt, emit_now;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign last_pt  = sts.j_eq_n || (CNT_W'(count_reg + 1'b1) == point_limit);
    assign emit_now = (cmd.op == OP_EMIT_PT) || (cmd.op == OP_EMIT_START);

    always_comb
    begin
        cmd.op       = OP_NONE;
        cmd.edge_sel = edge_reg;
        cmd.term     = term_reg;
        unique case (state_reg)
            S_IDLE:  cmd.op = accept ? OP_LOAD : OP_NONE;
            S_START:
            begin
                if (point_limit == '0)
                begin
                    cmd.op = OP_FINISH;
                end
                else if (out_free)
                begin
                    cmd.op = OP_EMIT_START;
                end
            end
            S_SQX:   cmd.op = OP_SQ_X;
            S_SQY:   cmd.op = OP_SQ_Y;
            S_SQRT:  cmd.op = OP_SQRT_STEP;
            S_EADD:  cmd.op = OP_EDGE_ADD;
            S_DIVI:  cmd.op = OP_DIV_INIT;
            S_DIV:   cmd.op = OP_DIV_STEP;
            S_NSET:  cmd.op = OP_N_SET;
            S_NSQ:   cmd.op = OP_N_SQ;
            S_NCUBE: cmd.op = OP_N_CUBE;
            S_PCHK:  cmd.op = OP_NONE;
            S_WSQ:   cmd.op = OP_W_SQ;
            S_WMUL:  cmd.op = OP_W_MUL;
            S_TERM:  cmd.op = OP_TERM;
            S_ACC:   cmd.op = OP_ACC;
            S_PDI:   cmd.op = OP_PDIV_INIT;
            S_PDIV:  cmd.op = OP_PDIV_STEP;
            S_EMIT:  cmd.op = out_free ? OP_EMIT_PT : OP_NONE;
            S_FIN:   cmd.op = OP_FINISH;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            edge_reg      <= '0;
            term_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // a new point replaces a taken one in the same cycle
            if (emit_now)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    edge_reg <= '0;
                    if (accept)
                    begin
                        state_reg <= (in_cmd == CMD_START) ? S_START : S_SQX;
                    end
                end
                S_START:
                begin
                    if (point_limit == '0)
                    begin
                        count_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        count_reg    <= CNT_W'(1);
                        out_last_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_SQX:   state_reg <= S_SQY;
                S_SQY:
                begin
                    step_reg  <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(SQRT_STEPS - 1))
                    begin
                        state_reg <= S_EADD;
                    end
                end
                S_EADD:
                begin
                    edge_reg  <= edge_reg + 1'b1;
                    state_reg <= (edge_reg == 2'd2) ? S_DIVI : S_SQX;
                end
                S_DIVI:
                begin
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(QDIV_STEPS - 1))
                    begin
                        state_reg <= S_NSET;
                    end
                end
                S_NSET:  state_reg <= S_NSQ;
                S_NSQ:   state_reg <= S_NCUBE;
                S_NCUBE: state_reg <= S_PCHK;
                S_PCHK:  state_reg <= (count_reg < point_limit) ? S_WSQ : S_FIN;
                S_WSQ:   state_reg <= S_WMUL;
                S_WMUL:
                begin
                    term_reg  <= '0;
                    state_reg <= S_TERM;
                end
                S_TERM:
                begin
                    term_reg <= term_reg + 1'b1;
                    if (term_reg == 2'd3)
                    begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:   state_reg <= S_PDI;
                S_PDI:
                begin
                    step_reg  <= '0;
                    state_reg <= S_PDIV;
                end
                S_PDIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(PDIV_STEPS - 1))
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        count_reg    <= count_reg + 1'b1;
                        out_last_reg <= last_pt;
                        state_reg    <= last_pt ? S_FIN : S_WSQ;
                    end
                end
                S_FIN:   state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;

    a_emit_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT_PT) |-> (count_reg < point_limit))
        else $error("point emitted at or beyond the point limit");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input taken without starting work");

    a_last_at_final_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT_PT && sts.j_eq_n) |=> (out_valid && out_last))
        else $error("final step of a segment not flagged last");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> (cmd.op != OP_EMIT_PT && cmd.op != OP_EMIT_START))
        else $error("output register overwritten while held");

endmodule

`default_nettype wire

FILE: rtl/cubic_bezier_flattener_top.sv
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_top: cubic Bezier subpath flattener
// Turns start and cubic segment items into a stream of Q16.16 points.
//
// Input stream (s_axis): one item per transfer. tuser is the command
// (start subpath or cubic segment), tdata carries the controls and end point.
// Output stream (m_axis): one point per transfer, tlast on the final point
// that an input item causes. An item that emits nothing gives no transfer.
// A segment item first works out its step count (three square roots for the
// control polygon edges, then a restoring divide by step_length) and then
// blends one point at a time, each ending in a bit-serial rounding divide.
// One item is worked on at a time; s_axis_tready is high only while idle.
// A point waits in the output register while the receiver stalls; the
// sequencer holds before the next point until that one is taken.
// Reset zeroes the current point and the point count, sets the point limit
// to 1024 and step_length to 3.0. Registers must be written over APB only
// while the block is idle (not enforced); reads return the stored value.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_flattener_top
    import cbf_pkg::*;
#(
    parameter int MAX_SEGMENT_STEPS = SEG_STEPS_CAP_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // slave stream
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    // ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y (32 bits each)
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command
    input  wire logic                  s_axis_tuser,
    // master stream
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // point_x, point_y (32 bits each)
    output      logic [OUT_DATA_W-1:0] m_axis_tdata,
    output      logic                  m_axis_tlast,
    // register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready
);

    logic [CNT_W-1:0] point_limit_reg;
    logic [LEN_W-1:0] step_length_reg;
    logic             cfg_wr;
    cmd_t             cmd;
    sts_t             sts;

    // no wait states; a write lands on the access cycle
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_limit_reg <= POINT_LIMIT_RESET;
            step_length_reg <= STEP_LENGTH_RESET;
        end
        else if (cfg_wr)
        begin
            // the low address bits are the byte offset within a word
            unique case (paddr[2])
                REG_POINT_LIMIT: point_limit_reg <= pwdata[CNT_W-1:0];
                REG_STEP_LENGTH: step_length_reg <= pwdata[LEN_W-1:0];
                default:         point_limit_reg <= point_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_POINT_LIMIT: prdata = APB_DATA_W'(point_limit_reg);
            REG_STEP_LENGTH: prdata = APB_DATA_W'(step_length_reg);
            default:         prdata = '0;
        endcase
    end

    // sequencer: edge lengths, step count, then one blend per point
    cbf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_cmd      (s_axis_tuser),
        .in_ready    (s_axis_tready),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_last    (m_axis_tlast),
        .point_limit (point_limit_reg),
        .sts         (sts),
        .cmd         (cmd)
    );

    // arithmetic and the output point register
    cbf_dp #(
        .SEG_STEPS_CAP (MAX_SEGMENT_STEPS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_data     (s_axis_tdata),
        .step_length (step_length_reg),
        .point       (m_axis_tdata)
    );

endmodule

`default_nettype wire
